// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the quadratic solver RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checks an implication or expression on every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Checks that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("assertion failed");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ----- hw/rtl/qs_pkg.sv -----
// Package of the quadratic solver: widths, payload and pipeline types, saturation.
// Used by every module of the solver; depends on nothing.
package qs_pkg;

  localparam int COEF_W     = 16;
  localparam int FRAC_BITS  = 8;
  localparam int SQRT_EXTRA = 8;
  localparam int Q_OUT      = 16;
  localparam int OUT_W      = 32;

  localparam int PROD_W  = 2 * COEF_W;
  localparam int AXX_W   = 3 * COEF_W;
  localparam int SLOPE_W = 2 * COEF_W + 2;
  localparam int DISC_W  = 2 * COEF_W + 3;
  localparam int VAL_W   = 3 * COEF_W + 2;
  localparam int SAT_IN_W = VAL_W;

  localparam int RND_SH   = 3 * FRAC_BITS - Q_OUT;
  localparam int RND_HALF = 1 << (RND_SH - 1);

  // The radicand is disc scaled by 2^(2*SQRT_EXTRA); disc stays below 2^33.
  localparam int RAD_W  = 50;
  localparam int ROOT_W = RAD_W / 2;
  localparam int SREM_W = ROOT_W + 3;

  // Root numerator magnitude plus half the divisor stays below 2^34.
  localparam int NUM_W  = 34;
  localparam int NUMS_W = NUM_W + 1;
  localparam int DEN_W  = COEF_W + 1;
  localparam int DREM_W = DEN_W + 1;

  localparam logic signed [OUT_W-1:0] Q_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] Q_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_A_ZERO   = 2'd1,
    ST_ALL_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
    logic signed [COEF_W-1:0] point_x;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value_at_x;
    logic signed [OUT_W-1:0] slope_at_x;
    logic [1:0]              root_count;
    logic signed [OUT_W-1:0] root_minus;
    logic signed [OUT_W-1:0] root_plus;
    logic [1:0]              status;
    logic                    overflow;
  } out_item_t;

  // Results settled early that ride along the root chains.
  typedef struct packed {
    logic signed [OUT_W-1:0]  value;
    logic signed [OUT_W-1:0]  slope;
    logic [1:0]               count;
    logic [1:0]               status;
    logic                     ov;
    logic                     roots_ok;
    logic                     neg_m;
    logic                     neg_p;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [NUM_W-1:0]  num_m;
    logic [NUM_W-1:0]  num_p;
    logic [DREM_W-1:0] rem_m;
    logic [DREM_W-1:0] rem_p;
    logic [NUM_W-1:0]  q_m;
    logic [NUM_W-1:0]  q_p;
    logic [DEN_W-1:0]  den;
  } div_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] v;
    logic                    ov;
  } sat_t;

  // Clamps a wide signed value to the 32-bit range and flags the clamp.
  function automatic sat_t sat32(input logic signed [SAT_IN_W-1:0] v);
    sat_t r;
    logic [SAT_IN_W-OUT_W:0] hi;
    hi = v[SAT_IN_W-1:OUT_W-1];
    r.ov = !((&hi) || (~|hi));
    if (r.ov) begin
      r.v = v[SAT_IN_W-1] ? Q_MIN : Q_MAX;
    end else begin
      r.v = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/quadratic_solver.sv -----
// Quadratic solver top level: front end, square-root chain, divider chain, output.
// Uses qs_pkg, qs_poly, qs_sqrt_cell, qs_div_cell and assert_macros.svh.
//
// The solver takes one coefficient set (a, b, c and a point x, signed Q8.8)
// per transfer and returns one result per transfer: f(x), the slope 2ax+b,
// the root count, both roots in Q16.16 with saturation, a status code and an
// overflow flag. It is a fully pipelined design that accepts a new set on
// every cycle in which the output side is not stalled, so the sustained rate
// is one item per clock. Between input transfer and output, each item
// passes through the front end registers for the products, f(x), slope and
// discriminant, a chain of square-root cells that each settle one bit of
// sqrt(disc), the stage that forms the root numerators, a chain of divider
// cells that each settle one quotient bit of both roots, and the output
// register. All stages advance together; while the output holds a result
// that is not taken, the whole pipeline holds, and input ready stays low for
// as long as that result waits. Empty slots travel through the pipeline like
// items, so a stall never loses or repeats a result. When a is zero, all
// coefficients are zero, or the discriminant is negative, both roots read as
// zero and do not raise the overflow flag.
`include "assert_macros.svh"

module quadratic_solver import qs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // The pipeline moves whenever the output register can take a new entry.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Front end.
  logic  sq_valid [ROOT_W+1];
  side_t sq_side  [ROOT_W+1];
  sqrt_t sq_data  [ROOT_W+1];

  qs_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .item_i  (in_item_i),
    .valid_o (sq_valid[0]),
    .side_o  (sq_side[0]),
    .data_o  (sq_data[0])
  );

  // Square-root chain: cell k settles root bit ROOT_W-1-k.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    qs_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (sq_valid[k]),
      .side_i  (sq_side[k]),
      .data_i  (sq_data[k]),
      .valid_o (sq_valid[k+1]),
      .side_o  (sq_side[k+1]),
      .data_o  (sq_data[k+1])
    );
  end

  // Numerator stage. Each root is (-b*2^8 -/+ s) * 2^8 / (2a), rounded to
  // nearest with ties away from zero, so the divider sees |num| + |a| and
  // the divisor 2|a|, and the sign is applied after the quotient.
  logic                     dv_valid [NUM_W+1];
  side_t                    dv_side  [NUM_W+1];
  div_t                     dv_data  [NUM_W+1];
  logic                     nv_q;
  side_t                    ns_d, ns_q;
  div_t                     nd_d, nd_q;
  logic signed [NUMS_W-1:0] nb, sv, nm, np, am, ap;
  logic signed [DEN_W-1:0]  ae;
  logic [DEN_W-1:0]         amag;

  always_comb begin
    nb   = -(NUMS_W'(sq_side[ROOT_W].coef_b) <<< SQRT_EXTRA);
    sv   = signed'(NUMS_W'(sq_data[ROOT_W].root));
    nm   = (nb - sv) <<< (Q_OUT - SQRT_EXTRA);
    np   = (nb + sv) <<< (Q_OUT - SQRT_EXTRA);
    am   = nm[NUMS_W-1] ? -nm : nm;
    ap   = np[NUMS_W-1] ? -np : np;
    ae   = DEN_W'(sq_side[ROOT_W].coef_a);
    amag = ae[DEN_W-1] ? $unsigned(-ae) : $unsigned(ae);

    ns_d       = sq_side[ROOT_W];
    ns_d.neg_m = nm[NUMS_W-1] ^ ae[DEN_W-1];
    ns_d.neg_p = np[NUMS_W-1] ^ ae[DEN_W-1];

    nd_d.num_m = am[NUM_W-1:0] + NUM_W'(amag);
    nd_d.num_p = ap[NUM_W-1:0] + NUM_W'(amag);
    nd_d.rem_m = '0;
    nd_d.rem_p = '0;
    nd_d.q_m   = '0;
    nd_d.q_p   = '0;
    nd_d.den   = amag << 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else if (adv) begin
      nv_q <= sq_valid[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ns_q <= ns_d;
      nd_q <= nd_d;
    end
  end

  assign dv_valid[0] = nv_q;
  assign dv_side[0]  = ns_q;
  assign dv_data[0]  = nd_q;

  // Divider chain: cell k settles quotient bit NUM_W-1-k of both roots.
  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    qs_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (dv_valid[k]),
      .side_i  (dv_side[k]),
      .data_i  (dv_data[k]),
      .valid_o (dv_valid[k+1]),
      .side_o  (dv_side[k+1]),
      .data_o  (dv_data[k+1])
    );
  end

  // Output stage: apply the signs, saturate, and zero the roots when the
  // equation has none to report.
  logic                      out_valid_q;
  out_item_t                 out_item_d, out_item_q;
  logic signed [SAT_IN_W-1:0] rm_w, rp_w;
  sat_t                      rm_sat, rp_sat;
  side_t                     fs;

  always_comb begin
    fs     = dv_side[NUM_W];
    rm_w   = fs.neg_m ? -SAT_IN_W'(dv_data[NUM_W].q_m) : SAT_IN_W'(dv_data[NUM_W].q_m);
    rp_w   = fs.neg_p ? -SAT_IN_W'(dv_data[NUM_W].q_p) : SAT_IN_W'(dv_data[NUM_W].q_p);
    rm_sat = sat32(rm_w);
    rp_sat = sat32(rp_w);

    out_item_d.value_at_x = fs.value;
    out_item_d.slope_at_x = fs.slope;
    out_item_d.root_count = fs.count;
    out_item_d.status     = fs.status;
    if (fs.roots_ok) begin
      out_item_d.root_minus = rm_sat.v;
      out_item_d.root_plus  = rp_sat.v;
      out_item_d.overflow   = fs.ov | rm_sat.ov | rp_sat.ov;
    end else begin
      out_item_d.root_minus = '0;
      out_item_d.root_plus  = '0;
      out_item_d.overflow   = fs.ov;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_valid[NUM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A set without usable roots must leave both roots at zero.
  `ASSERT_AT(a_status_roots_zero, clk_i, rst_ni, out_valid_o && (out_item_o.status != ST_OK) |-> (out_item_o.root_minus == '0) && (out_item_o.root_plus == '0))
  `ASSERT_AT(a_count_roots_zero, clk_i, rst_ni, out_valid_o && (out_item_o.root_count == CNT_NONE) |-> (out_item_o.root_minus == '0) && (out_item_o.root_plus == '0))
  // All-zero coefficients give a zero discriminant.
  `ASSERT_AT(a_all_zero_count, clk_i, rst_ni, out_valid_o && (out_item_o.status == ST_ALL_ZERO) |-> out_item_o.root_count == CNT_ONE)
  // A single root means both roots coincide.
  `ASSERT_NEVER(a_one_root_equal, clk_i, rst_ni, out_valid_o && (out_item_o.root_count == CNT_ONE) && (out_item_o.root_minus != out_item_o.root_plus))

endmodule

// ----- hw/rtl/qs_poly.sv -----
// Front end of the quadratic solver: products, f(x), slope, discriminant, status.
// Three register stages; uses qs_pkg.
module qs_poly import qs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  logic     valid_i,
  input  in_item_t item_i,
  output logic     valid_o,
  output side_t    side_o,
  output sqrt_t    data_o
);

  logic                     v1_q, v2_q, v3_q;
  logic signed [COEF_W-1:0] a1_q, b1_q, c1_q, x1_q;
  logic signed [PROD_W-1:0] ax1_q, bx1_q, bb1_q, ac1_q;

  logic signed [COEF_W-1:0]  a2_q, b2_q, c2_q;
  logic signed [PROD_W-1:0]  bx2_q;
  logic signed [AXX_W-1:0]   axx2_q;
  logic signed [SLOPE_W-1:0] slope2_q;
  logic signed [DISC_W-1:0]  disc2_q;
  logic [1:0]                status2_q;

  logic signed [VAL_W-1:0] val_sum, val_rnd;
  sat_t                    val_sat, slope_sat;
  logic                    disc_neg;
  side_t                   side_d, side_q;
  sqrt_t                   data_d, data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a1_q  <= item_i.coef_a;
      b1_q  <= item_i.coef_b;
      c1_q  <= item_i.coef_c;
      x1_q  <= item_i.point_x;
      ax1_q <= PROD_W'(item_i.coef_a) * PROD_W'(item_i.point_x);
      bx1_q <= PROD_W'(item_i.coef_b) * PROD_W'(item_i.point_x);
      bb1_q <= PROD_W'(item_i.coef_b) * PROD_W'(item_i.coef_b);
      ac1_q <= PROD_W'(item_i.coef_a) * PROD_W'(item_i.coef_c);

      a2_q     <= a1_q;
      b2_q     <= b1_q;
      c2_q     <= c1_q;
      bx2_q    <= bx1_q;
      axx2_q   <= AXX_W'(ax1_q) * AXX_W'(x1_q);
      slope2_q <= (SLOPE_W'(ax1_q) <<< 1) + (SLOPE_W'(b1_q) <<< FRAC_BITS);
      disc2_q  <= DISC_W'(bb1_q) - (DISC_W'(ac1_q) <<< 2);
      if (a1_q == '0 && b1_q == '0 && c1_q == '0) begin
        status2_q <= ST_ALL_ZERO;
      end else if (a1_q == '0) begin
        status2_q <= ST_A_ZERO;
      end else begin
        status2_q <= ST_OK;
      end

      side_q <= side_d;
      data_q <= data_d;
    end
  end

  always_comb begin
    val_sum = VAL_W'(axx2_q) + (VAL_W'(bx2_q) <<< FRAC_BITS)
            + (VAL_W'(c2_q) <<< (2 * FRAC_BITS));
    val_rnd = (val_sum + VAL_W'(RND_HALF)) >>> RND_SH;
    val_sat   = sat32(val_rnd);
    slope_sat = sat32(SAT_IN_W'(slope2_q));
    disc_neg  = disc2_q[DISC_W-1];

    side_d.value    = val_sat.v;
    side_d.slope    = slope_sat.v;
    side_d.ov       = val_sat.ov | slope_sat.ov;
    side_d.status   = status2_q;
    side_d.roots_ok = (status2_q == ST_OK) && !disc_neg;
    side_d.neg_m    = 1'b0;
    side_d.neg_p    = 1'b0;
    side_d.coef_a   = a2_q;
    side_d.coef_b   = b2_q;
    if (disc_neg) begin
      side_d.count = CNT_NONE;
    end else if (disc2_q == '0) begin
      side_d.count = CNT_ONE;
    end else begin
      side_d.count = CNT_TWO;
    end

    data_d.rad  = disc_neg ? '0 : (RAD_W'($unsigned(disc2_q)) << (2 * SQRT_EXTRA));
    data_d.rem  = '0;
    data_d.root = '0;
  end

  assign valid_o = v3_q;
  assign side_o  = side_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/qs_sqrt_cell.sv -----
// One cell of the square-root chain: settles one root bit per cell.
// Restoring digit-by-digit step; uses qs_pkg.
module qs_sqrt_cell import qs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  valid_i,
  input  side_t side_i,
  input  sqrt_t data_i,
  output logic  valid_o,
  output side_t side_o,
  output sqrt_t data_o
);

  logic              valid_q;
  side_t             side_q;
  sqrt_t             data_d, data_q;
  logic [SREM_W-1:0] rem_sh, trial;

  always_comb begin
    rem_sh = {data_i.rem[SREM_W-3:0], data_i.rad[RAD_W-1 -: 2]};
    trial  = {{(SREM_W-ROOT_W-2){1'b0}}, data_i.root, 2'b01};
    data_d.rad = data_i.rad << 2;
    if (rem_sh >= trial) begin
      data_d.rem  = rem_sh - trial;
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_sh;
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q <= side_i;
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/qs_div_cell.sv -----
// One cell of the root divider chain: one quotient bit for both roots per cell.
// Restoring division with a shared divisor; uses qs_pkg.
module qs_div_cell import qs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  valid_i,
  input  side_t side_i,
  input  div_t  data_i,
  output logic  valid_o,
  output side_t side_o,
  output div_t  data_o
);

  logic              valid_q;
  side_t             side_q;
  div_t              data_d, data_q;
  logic [DREM_W-1:0] sh_m, sh_p, den_x;

  always_comb begin
    den_x = {1'b0, data_i.den};
    sh_m  = {data_i.rem_m[DREM_W-2:0], data_i.num_m[NUM_W-1]};
    sh_p  = {data_i.rem_p[DREM_W-2:0], data_i.num_p[NUM_W-1]};
    data_d.den   = data_i.den;
    data_d.num_m = data_i.num_m << 1;
    data_d.num_p = data_i.num_p << 1;
    if (sh_m >= den_x) begin
      data_d.rem_m = sh_m - den_x;
      data_d.q_m   = {data_i.q_m[NUM_W-2:0], 1'b1};
    end else begin
      data_d.rem_m = sh_m;
      data_d.q_m   = {data_i.q_m[NUM_W-2:0], 1'b0};
    end
    if (sh_p >= den_x) begin
      data_d.rem_p = sh_p - den_x;
      data_d.q_p   = {data_i.q_p[NUM_W-2:0], 1'b1};
    end else begin
      data_d.rem_p = sh_p;
      data_d.q_p   = {data_i.q_p[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q <= side_i;
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign data_o  = data_q;

endmodule

// ----- verif/testbench.sv -----
// Testbench for the quadratic solver: directed and random coefficient sets, with a predictor.
// Depends on qs_pkg and the quadratic_solver RTL; reads no files.
`timescale 1ns / 100ps

module testbench;
  import qs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  quadratic_solver dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  // Expected results, oldest first, in the order the coefficient sets were sent.
  out_item_t solutions_q[$];
  int        error_count;
  int        idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Rounds to nearest with ties toward +infinity while dropping s fraction bits.
  function automatic longint round_drop(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Clamps to the signed 32-bit range and records any clamp in ov.
  function automatic logic [31:0] clamp32(longint v, ref logic ov);
    if (v > longint'(32'sh7fffffff)) begin
      ov = 1'b1;
      return Q_MAX;
    end
    if (v < -longint'(64'h80000000)) begin
      ov = 1'b1;
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // Quotient rounded to nearest, ties away from zero, then clamped.
  function automatic logic [31:0] root_quotient(longint num, longint den, ref logic ov);
    logic neg;
    longint unsigned un;
    longint unsigned ud;
    longint unsigned q;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = (un + ud / 2) / ud;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return clamp32(neg ? -longint'(q) : longint'(q), ov);
  endfunction

  function automatic out_item_t solve_quadratic(in_item_t item);
    out_item_t r;
    longint a, b, c, x, val, slope, disc, sq, nb;
    logic ov;
    a = item.coef_a;
    b = item.coef_b;
    c = item.coef_c;
    x = item.point_x;
    ov = 1'b0;
    val = a * x * x + b * x * 256 + c * 65536;
    slope = 2 * a * x + b * 256;
    disc = b * b - 4 * a * c;
    r = '0;
    r.root_count = disc > 0 ? CNT_TWO : (disc == 0 ? CNT_ONE : CNT_NONE);
    if (a == 0 && b == 0 && c == 0) r.status = ST_ALL_ZERO;
    else if (a == 0) r.status = ST_A_ZERO;
    else r.status = ST_OK;
    r.value_at_x = clamp32(round_drop(val, 8), ov);
    // The slope already has 16 fraction bits.
    r.slope_at_x = clamp32(slope, ov);
    if (r.status == ST_OK && disc >= 0) begin
      sq = floor_sqrt(longint'(disc) << 16);
      nb = -b * 256;
      r.root_minus = root_quotient((nb - sq) * 256, 2 * a, ov);
      r.root_plus = root_quotient((nb + sq) * 256, 2 * a, ov);
    end
    r.overflow = ov;
    return r;
  endfunction

  // Sends one coefficient set after a random gap and records its expected result.
  // Valid stays high into the next set when that set follows without a gap.
  task automatic send_coefficients(in_item_t item);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    solutions_q.push_back(solve_quadratic(item));
    @(negedge clk);
  endtask

  function automatic in_item_t make_item(int a, int b, int c, int x);
    in_item_t it;
    it.coef_a = a[15:0];
    it.coef_b = b[15:0];
    it.coef_c = c[15:0];
    it.point_x = x[15:0];
    return it;
  endfunction

  // Output stall: ready drops for a random number of cycles before each result.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Result checker: every transfer on the output is compared with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (solutions_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        error_count++;
      end else begin
        want = solutions_q.pop_front();
        if (want.value_at_x !== out_item.value_at_x) begin
          $display("%0t: value_at_x expected %h actual %h", $time,
                   want.value_at_x, out_item.value_at_x);
          error_count++;
        end
        if (want.slope_at_x !== out_item.slope_at_x) begin
          $display("%0t: slope_at_x expected %h actual %h", $time,
                   want.slope_at_x, out_item.slope_at_x);
          error_count++;
        end
        if (want.root_count !== out_item.root_count) begin
          $display("%0t: root_count expected %0d actual %0d", $time,
                   want.root_count, out_item.root_count);
          error_count++;
        end
        if (want.root_minus !== out_item.root_minus) begin
          $display("%0t: root_minus expected %h actual %h", $time,
                   want.root_minus, out_item.root_minus);
          error_count++;
        end
        if (want.root_plus !== out_item.root_plus) begin
          $display("%0t: root_plus expected %h actual %h", $time,
                   want.root_plus, out_item.root_plus);
          error_count++;
        end
        if (want.status !== out_item.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_item.status);
          error_count++;
        end
        if (want.overflow !== out_item.overflow) begin
          $display("%0t: overflow expected %0d actual %0d", $time,
                   want.overflow, out_item.overflow);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles without any transfer on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Extremes of every field and each special case: zero a, all-zero triple,
  // negative, zero and positive discriminant, and saturation of every output.
  task automatic test_directed();
    send_coefficients(make_item(0, 0, 0, 0));
    send_coefficients(make_item(0, 0, 0, 32767));
    send_coefficients(make_item(0, 256, -512, 100));
    send_coefficients(make_item(0, 0, 5, -3));
    send_coefficients(make_item(256, 0, 256, 0));
    send_coefficients(make_item(256, -512, 256, 256));
    send_coefficients(make_item(256, 0, -1024, 512));
    send_coefficients(make_item(-256, 768, -512, -256));
    send_coefficients(make_item(32767, 32767, 32767, 32767));
    send_coefficients(make_item(-32768, -32768, -32768, -32768));
    send_coefficients(make_item(32767, -32768, 32767, -32768));
    send_coefficients(make_item(-32768, 32767, -32768, 32767));
    send_coefficients(make_item(1, 32767, -32768, 1));
    send_coefficients(make_item(1, -32768, 32767, -1));
    send_coefficients(make_item(-1, 32767, 32767, 0));
    send_coefficients(make_item(1, 0, -32768, 32767));
    send_coefficients(make_item(-1, 0, 32767, -32768));
    send_coefficients(make_item(1, 2, 1, 1));
    send_coefficients(make_item(-1, -1, -1, -1));
    send_coefficients(make_item(2, 1, 0, 0));
    send_coefficients(make_item(-2, 1, 0, 5));
  endtask

  // Random sets: mostly full range, some small coefficients that give in-range roots.
  task automatic test_random(int count);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      it = in_item_t'({$urandom, $urandom});
      case ($urandom_range(0, 5))
        0: it.coef_a = $urandom_range(0, 1) ? 16'sd0 : it.coef_a;
        1: begin
          it.coef_a = 16'($signed($urandom_range(0, 1023)) - 512);
          it.coef_b = 16'($signed($urandom_range(0, 4095)) - 2048);
          it.coef_c = 16'($signed($urandom_range(0, 4095)) - 2048);
        end
        2: it.point_x = 16'($signed($urandom_range(0, 2047)) - 1024);
        default: ;
      endcase
      send_coefficients(it);
    end
  endtask

  // Releases the input and waits until every expected result has arrived.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (solutions_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    error_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(1500);
    wait_drain();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
